FILE: rtl/core/bir_pkg.sv
`default_nettype none

package bir_pkg;

	localparam int COORD_W   = 10;
	localparam int PIX_W     = 8;
	localparam int OUT_W     = 16;
	localparam int STEP_W    = 24;
	localparam int FRAC_W    = 16;
	localparam int INSZ_W    = 8;
	localparam int OUTSZ_W   = 11;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int BANKS     = 4;

	localparam logic [STEP_W-1:0] STEP_ONE = 24'h010000;

	localparam int RSP_DEPTH = 8;
	localparam int RSP_PTR_W = 3;
	localparam int RSP_CNT_W = 4;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef enum logic [1:0] {
		REG_IN_WIDTH   = 2'd0,
		REG_IN_HEIGHT  = 2'd1,
		REG_OUT_WIDTH  = 2'd2,
		REG_OUT_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [1:0]         chan;
		logic [PIX_W-1:0]   pixel_in;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] pixel_out;
		logic             range_error;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/bilinear_image_resize_core.sv
// A pixel request gives its result through stages s1 to s5 and then the response queue; loads give none.
// Throughput: one request or load per cycle while req_ready is high, set by the four frame store banks
// (column and row parity) that serve all four neighbours in a single read.
// A size write recomputes that axis step in a bit-serial divider (a start step, then
// one quotient bit per cycle); req_ready stays low until the steps are settled.
// Reset: sizes 128, steps 1.0, response queue empty; frame store undefined until loaded.
`default_nettype none

module bilinear_image_resize_core #(
	parameter int MAX_IN_W     = 128,
	parameter int MAX_IN_H     = 128,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bir_pkg::PADDR_W-1:0] paddr,
	input  logic [bir_pkg::PDATA_W-1:0] pwdata,
	output logic [bir_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  bir_pkg::req_t               req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output bir_pkg::rsp_t               rsp_data
);

	localparam int CIW = (MAX_IN_W > 1) ? $clog2(MAX_IN_W) : 1;
	localparam int RIW = (MAX_IN_H > 1) ? $clog2(MAX_IN_H) : 1;
	localparam int HCW = (CIW > 1) ? CIW - 1 : 1;
	localparam int HRW = (RIW > 1) ? RIW - 1 : 1;
	localparam int CHB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int BAW = HRW + HCW + CHB;
	localparam int BANK_DEPTH = 1 << BAW;
	localparam int POS_W = bir_pkg::COORD_W + bir_pkg::STEP_W;
	localparam int IDX_W = POS_W - bir_pkg::FRAC_W;
	localparam int WGT_W = 2 * bir_pkg::FRAC_W + 1;
	localparam int PRD_W = WGT_W + bir_pkg::PIX_W;
	localparam logic [PRD_W-1:0] ROUND_HALF = PRD_W'(1) << 23;
	localparam logic [4:0] DIV_LAST = 5'(bir_pkg::STEP_W - 1);

	// ---------------- configuration ----------------
	logic [7:0]  in_width_q, in_height_q;
	logic [10:0] out_width_q, out_height_q;
	logic        cfg_wr;
	bir_pkg::cfg_reg_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = bir_pkg::cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= 8'd128;
			in_height_q  <= 8'd128;
			out_width_q  <= 11'd128;
			out_height_q <= 11'd128;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bir_pkg::REG_IN_WIDTH:   in_width_q   <= pwdata[7:0];
				bir_pkg::REG_IN_HEIGHT:  in_height_q  <= pwdata[7:0];
				bir_pkg::REG_OUT_WIDTH:  out_width_q  <= pwdata[10:0];
				bir_pkg::REG_OUT_HEIGHT: out_height_q <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			bir_pkg::REG_IN_WIDTH:   prdata = {24'd0, in_width_q};
			bir_pkg::REG_IN_HEIGHT:  prdata = {24'd0, in_height_q};
			bir_pkg::REG_OUT_WIDTH:  prdata = {21'd0, out_width_q};
			bir_pkg::REG_OUT_HEIGHT: prdata = {21'd0, out_height_q};
		endcase
	end

	function automatic logic [7:0] eff_in(input logic [7:0] v, input logic [12:0] maxv);
		logic [7:0] r;
		r = v;
		if (v == 8'd0)
			r = 8'd1;
		else if ({5'd0, v} > maxv)
			r = maxv[7:0];
		return r;
	endfunction

	logic [7:0]  iw_eff, ih_eff, last_c, last_r;
	logic [10:0] ow_eff, oh_eff;

	assign iw_eff = eff_in(in_width_q, 13'(MAX_IN_W));
	assign ih_eff = eff_in(in_height_q, 13'(MAX_IN_H));
	assign ow_eff = (out_width_q == 11'd0) ? 11'd1 : out_width_q;
	assign oh_eff = (out_height_q == 11'd0) ? 11'd1 : out_height_q;
	assign last_c = iw_eff - 8'd1;
	assign last_r = ih_eff - 8'd1;

	// ---------------- step divider ----------------
	logic [bir_pkg::STEP_W-1:0] col_step_q, row_step_q;
	logic [1:0]  pend_q, pend_clr;
	logic        div_busy_q, div_axis_q;
	logic [4:0]  div_cnt_q;
	logic [23:0] div_num_q;
	logic [10:0] div_den_q, div_rem_q;
	logic        wr_col, wr_row, div_abort, div_start, start_axis;
	logic [10:0] col_den, row_den, start_den;
	logic [23:0] col_num, row_num, start_num;
	logic [11:0] div_trial, div_diff;
	logic        div_ge;
	logic [10:0] div_rem_nxt;
	logic [23:0] div_quot;

	assign wr_col = cfg_wr && (cfg_idx == bir_pkg::REG_IN_WIDTH ||
		cfg_idx == bir_pkg::REG_OUT_WIDTH);
	assign wr_row = cfg_wr && (cfg_idx == bir_pkg::REG_IN_HEIGHT ||
		cfg_idx == bir_pkg::REG_OUT_HEIGHT);

	assign col_den = ow_eff - 11'd1;
	assign row_den = oh_eff - 11'd1;
	assign col_num = {last_c, 16'h0000} + 24'(col_den[10:1]);
	assign row_num = {last_r, 16'h0000} + 24'(row_den[10:1]);

	assign div_abort  = div_busy_q && ((wr_col && !div_axis_q) || (wr_row && div_axis_q));
	assign div_start  = !div_busy_q && !cfg_wr && (pend_q != 2'b00);
	assign start_axis = !pend_q[0];
	assign start_den  = start_axis ? row_den : col_den;
	assign start_num  = start_axis ? row_num : col_num;
	assign pend_clr   = div_start ? (start_axis ? 2'b10 : 2'b01) : 2'b00;

	assign div_trial   = {div_rem_q, div_num_q[23]};
	assign div_diff    = div_trial - {1'b0, div_den_q};
	assign div_ge      = div_trial >= {1'b0, div_den_q};
	assign div_rem_nxt = div_ge ? div_diff[10:0] : div_trial[10:0];
	assign div_quot    = {div_num_q[22:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 2'b00;
			div_busy_q <= 1'b0;
			div_axis_q <= 1'b0;
			div_cnt_q  <= 5'd0;
			col_step_q <= bir_pkg::STEP_ONE;
			row_step_q <= bir_pkg::STEP_ONE;
		end else begin
			pend_q <= (pend_q & ~pend_clr) | {wr_row, wr_col};
			if (div_abort) begin
				div_busy_q <= 1'b0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_cnt_q == DIV_LAST) begin
					div_busy_q <= 1'b0;
					if (div_axis_q)
						row_step_q <= div_quot;
					else
						col_step_q <= div_quot;
				end
			end else if (div_start) begin
				div_axis_q <= start_axis;
				div_cnt_q  <= 5'd0;
				if (start_den == 11'd0) begin
					if (start_axis)
						row_step_q <= '0;
					else
						col_step_q <= '0;
				end else begin
					div_busy_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_busy_q) begin
			div_num_q <= div_quot;
			div_rem_q <= div_rem_nxt;
		end else if (div_start) begin
			div_num_q <= start_num;
			div_den_q <= start_den;
			div_rem_q <= '0;
		end
	end

	// ---------------- request intake ----------------
	logic [bir_pkg::RSP_CNT_W-1:0] req_cnt_q;
	logic in_fire, out_fire, chan_ok, ld_ok, rq_err;

	assign req_ready = !div_busy_q && (pend_q == 2'b00) &&
		(req_cnt_q < bir_pkg::RSP_CNT_W'(bir_pkg::RSP_DEPTH));
	assign in_fire  = req_valid && req_ready;

	assign chan_ok = {1'b0, req_data.chan} < 3'(MAX_CHANNELS);
	assign ld_ok   = ({2'd0, iw_eff} > req_data.col) && ({2'd0, ih_eff} > req_data.row) &&
		chan_ok;
	assign rq_err  = ({1'b0, req_data.col} >= ow_eff) || ({1'b0, req_data.row} >= oh_eff) ||
		!chan_ok;

	// ---------------- s1: scale ----------------
	logic                        rq_s1, wr_s1, err_s1;
	logic [bir_pkg::COORD_W-1:0] col_s1, row_s1;
	logic [CHB-1:0]              chan_s1;
	logic [bir_pkg::PIX_W-1:0]   pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_s1 <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			rq_s1 <= in_fire && (req_data.req_type == bir_pkg::REQ_PIXEL);
			wr_s1 <= in_fire && (req_data.req_type == bir_pkg::REQ_LOAD) && ld_ok;
		end
	end

	always_ff @(posedge clk) begin
		err_s1  <= rq_err;
		col_s1  <= req_data.col;
		row_s1  <= req_data.row;
		chan_s1 <= req_data.chan[CHB-1:0];
		pix_s1  <= req_data.pixel_in;
	end

	// ---------------- s2: map and read ----------------
	logic             rq_s2, wr_s2, err_s2;
	logic [POS_W-1:0] pos_c_s2, pos_r_s2;
	logic [7:0]       lcol_s2, lrow_s2;
	logic [CHB-1:0]   chan_s2;
	logic [7:0]       pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_s2 <= 1'b0;
			wr_s2 <= 1'b0;
		end else begin
			rq_s2 <= rq_s1;
			wr_s2 <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		pos_c_s2 <= POS_W'(col_s1) * POS_W'(col_step_q);
		pos_r_s2 <= POS_W'(row_s1) * POS_W'(row_step_q);
		err_s2   <= err_s1;
		lcol_s2  <= col_s1[7:0];
		lrow_s2  <= row_s1[7:0];
		chan_s2  <= chan_s1;
		pix_s2   <= pix_s1;
	end

	logic [IDX_W-1:0] ic, ir;
	logic             c_over, r_over;
	logic [7:0]       c0, c1, r0, r1;
	logic [15:0]      fc, fr;
	logic [CIW:0]     c0e, c1e;
	logic [RIW:0]     r0e, r1e;
	logic [CIW:0]     bank_col [bir_pkg::BANKS];
	logic [RIW:0]     bank_row [bir_pkg::BANKS];
	logic [BAW-1:0]   bank_addr [bir_pkg::BANKS];
	logic [bir_pkg::BANKS-1:0] bank_we;

	always_comb begin
		ic     = pos_c_s2[POS_W-1:bir_pkg::FRAC_W];
		ir     = pos_r_s2[POS_W-1:bir_pkg::FRAC_W];
		c_over = ic > IDX_W'(last_c);
		r_over = ir > IDX_W'(last_r);
		c0     = rq_s2 ? (c_over ? last_c : ic[7:0]) : lcol_s2;
		r0     = rq_s2 ? (r_over ? last_r : ir[7:0]) : lrow_s2;
		fc     = c_over ? 16'd0 : pos_c_s2[15:0];
		fr     = r_over ? 16'd0 : pos_r_s2[15:0];
		c1     = (c0 == last_c) ? last_c : c0 + 8'd1;
		r1     = (r0 == last_r) ? last_r : r0 + 8'd1;
		c0e    = (CIW+1)'(c0);
		c1e    = (CIW+1)'(c1);
		r0e    = (RIW+1)'(r0);
		r1e    = (RIW+1)'(r1);
		for (int b = 0; b < bir_pkg::BANKS; b++) begin
			bank_col[b]  = (c0[0] == b[0]) ? c0e : c1e;
			bank_row[b]  = (r0[0] == b[1]) ? r0e : r1e;
			bank_addr[b] = {bank_row[b][HRW:1], bank_col[b][HCW:1], chan_s2};
			bank_we[b]   = wr_s2 && (c0[0] == b[0]) && (r0[0] == b[1]);
		end
	end

	logic [7:0] bank_rd_s3 [bir_pkg::BANKS];

	for (genvar b = 0; b < bir_pkg::BANKS; b++) begin : g_bank
		logic [7:0] mem [BANK_DEPTH];
		always_ff @(posedge clk) begin
			if (bank_we[b])
				mem[bank_addr[b]] <= pix_s2;
			bank_rd_s3[b] <= mem[bank_addr[b]];
		end
	end

	// ---------------- s3: weights ----------------
	logic        rq_s3, err_s3;
	logic [15:0] fc_s3, fr_s3;
	logic        c0p_s3, c1p_s3, r0p_s3, r1p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rq_s3 <= 1'b0;
		else
			rq_s3 <= rq_s2;
	end

	always_ff @(posedge clk) begin
		err_s3 <= err_s2;
		fc_s3  <= fc;
		fr_s3  <= fr;
		c0p_s3 <= c0[0];
		c1p_s3 <= c1[0];
		r0p_s3 <= r0[0];
		r1p_s3 <= r1[0];
	end

	logic [16:0] gc, gr;

	assign gc = 17'h10000 - {1'b0, fc_s3};
	assign gr = 17'h10000 - {1'b0, fr_s3};

	logic             rq_s4, err_s4;
	logic [WGT_W-1:0] w_s4 [bir_pkg::BANKS];
	logic [7:0]       v_s4 [bir_pkg::BANKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rq_s4 <= 1'b0;
		else
			rq_s4 <= rq_s3;
	end

	always_ff @(posedge clk) begin
		err_s4  <= err_s3;
		w_s4[0] <= WGT_W'(gc * gr);
		w_s4[1] <= WGT_W'({1'b0, fc_s3} * gr);
		w_s4[2] <= WGT_W'(gc * {1'b0, fr_s3});
		w_s4[3] <= WGT_W'({1'b0, fc_s3} * {1'b0, fr_s3});
		v_s4[0] <= bank_rd_s3[{r0p_s3, c0p_s3}];
		v_s4[1] <= bank_rd_s3[{r0p_s3, c1p_s3}];
		v_s4[2] <= bank_rd_s3[{r1p_s3, c0p_s3}];
		v_s4[3] <= bank_rd_s3[{r1p_s3, c1p_s3}];
	end

	// ---------------- s5: blend ----------------
	logic             rq_s5, err_s5;
	logic [PRD_W-1:0] prod_s5 [bir_pkg::BANKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rq_s5 <= 1'b0;
		else
			rq_s5 <= rq_s4;
	end

	always_ff @(posedge clk) begin
		err_s5 <= err_s4;
		for (int b = 0; b < bir_pkg::BANKS; b++)
			prod_s5[b] <= PRD_W'(w_s4[b] * v_s4[b]);
	end

	logic [PRD_W-1:0] blend_sum;
	bir_pkg::rsp_t    rsp_new;

	assign blend_sum = prod_s5[0] + prod_s5[1] + prod_s5[2] + prod_s5[3] + ROUND_HALF;
	assign rsp_new.pixel_out   = err_s5 ? '0 : blend_sum[39:24];
	assign rsp_new.range_error = err_s5;

	// ---------------- response queue ----------------
	bir_pkg::rsp_t rsp_q [bir_pkg::RSP_DEPTH];
	logic [bir_pkg::RSP_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [bir_pkg::RSP_CNT_W-1:0] fifo_cnt_q;
	logic in_req;

	assign rsp_valid = fifo_cnt_q != '0;
	assign rsp_data  = rsp_q[rd_ptr_q];
	assign out_fire  = rsp_valid && rsp_ready;
	assign in_req    = in_fire && (req_data.req_type == bir_pkg::REQ_PIXEL);

	always_ff @(posedge clk) begin
		if (rq_s5)
			rsp_q[wr_ptr_q] <= rsp_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			req_cnt_q  <= '0;
		end else begin
			if (rq_s5)
				wr_ptr_q <= wr_ptr_q + bir_pkg::RSP_PTR_W'(1);
			if (out_fire)
				rd_ptr_q <= rd_ptr_q + bir_pkg::RSP_PTR_W'(1);
			fifo_cnt_q <= fifo_cnt_q + bir_pkg::RSP_CNT_W'(rq_s5) -
				bir_pkg::RSP_CNT_W'(out_fire);
			req_cnt_q  <= req_cnt_q + bir_pkg::RSP_CNT_W'(in_req) -
				bir_pkg::RSP_CNT_W'(out_fire);
		end
	end

	// ---------------- checks ----------------
	a_req_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		req_cnt_q <= bir_pkg::RSP_CNT_W'(bir_pkg::RSP_DEPTH))
		else $error("request count exceeds queue depth");

	a_cnt_covers_fifo: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= req_cnt_q)
		else $error("queue holds more than outstanding requests");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_req |-> ##5 rq_s5)
		else $error("request did not reach blend stage on time");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.range_error) |-> (rsp_data.pixel_out == '0))
		else $error("range error with nonzero pixel");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;

	localparam int SRC_MAX_W       = 128;
	localparam int SRC_MAX_H       = 128;
	localparam int CHANNELS        = 4;
	localparam int SRC_DEPTH       = SRC_MAX_W * SRC_MAX_H * CHANNELS;
	localparam int ITEMS_PER_PHASE = 105;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [bir_pkg::PADDR_W-1:0]   paddr     = '0;
	logic [bir_pkg::PDATA_W-1:0]   pwdata    = '0;
	logic [bir_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;
	logic                          req_valid = 1'b0;
	logic                          req_ready;
	bir_pkg::req_t                 req_data  = '0;
	logic                          rsp_valid;
	logic                          rsp_ready = 1'b0;
	bir_pkg::rsp_t                 rsp_data;
	logic                          hold_pulse = 1'b0;

	bir_pkg::req_t req_pending_q[$];
	bir_pkg::rsp_t exp_pixels_q[$];
	logic [7:0]    src_pixels [SRC_DEPTH];
	bit            src_loaded [SRC_DEPTH];

	logic [bir_pkg::INSZ_W-1:0]  reg_in_w, reg_in_h;
	logic [bir_pkg::OUTSZ_W-1:0] reg_out_w, reg_out_h;
	int unsigned eff_iw, eff_ih, eff_ow, eff_oh;
	int unsigned col_step, row_step;

	int err_cnt   = 0;
	int gen_cnt   = 0;
	int gap_left  = 0;
	int send_run  = 0;
	int stall_cnt = 0;
	int run_cnt   = 0;
	int rdy_pick;
	bit fire;

	bilinear_image_resize_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned step_of(input int unsigned in_sz, input int unsigned out_sz);
		int unsigned d;
		d = out_sz - 1;
		if (d == 0) begin
			return 0;
		end
		return ((((in_sz - 1) << 16) + d / 2) / d) & 32'h00FF_FFFF;
	endfunction

	function automatic void update_steps();
		eff_iw   = (reg_in_w == 0) ? 1 : ((reg_in_w > SRC_MAX_W) ? SRC_MAX_W : reg_in_w);
		eff_ih   = (reg_in_h == 0) ? 1 : ((reg_in_h > SRC_MAX_H) ? SRC_MAX_H : reg_in_h);
		eff_ow   = (reg_out_w == 0) ? 1 : reg_out_w;
		eff_oh   = (reg_out_h == 0) ? 1 : reg_out_h;
		col_step = step_of(eff_iw, eff_ow);
		row_step = step_of(eff_ih, eff_oh);
	endfunction

	function automatic int unsigned pix_addr(input int unsigned c, input int unsigned r,
		input int unsigned ch);
		return (r * SRC_MAX_W + c) * CHANNELS + ch;
	endfunction

	function automatic void map_axis(input int unsigned coord, input int unsigned step,
		input int unsigned in_sz, output int unsigned idx, output int unsigned nxt,
		output longint unsigned frac);
		longint unsigned pos;
		pos = coord;
		pos = pos * step;
		if ((pos >> 16) > in_sz - 1) begin
			idx  = in_sz - 1;
			frac = 0;
		end else begin
			idx  = 32'(pos >> 16);
			frac = pos & 64'hFFFF;
		end
		nxt = (idx + 1 > in_sz - 1) ? in_sz - 1 : idx + 1;
	endfunction

	function automatic void predict_resize(input bir_pkg::req_t q);
		int unsigned c0, c1, r0, r1;
		longint unsigned fc, fr, gc, gr, acc;
		bir_pkg::rsp_t e;
		if (q.req_type == bir_pkg::REQ_LOAD) begin
			if (q.col < eff_iw && q.row < eff_ih) begin
				src_pixels[pix_addr(32'(q.col), 32'(q.row), 32'(q.chan))] = q.pixel_in;
			end
			return;
		end
		e = '0;
		e.range_error = 1'b1;
		if (q.col < eff_ow && q.row < eff_oh) begin
			map_axis(32'(q.col), col_step, eff_iw, c0, c1, fc);
			map_axis(32'(q.row), row_step, eff_ih, r0, r1, fr);
			gc  = 65536 - fc;
			gr  = 65536 - fr;
			acc = gc * gr * src_pixels[pix_addr(c0, r0, 32'(q.chan))]
			    + fc * gr * src_pixels[pix_addr(c1, r0, 32'(q.chan))]
			    + gc * fr * src_pixels[pix_addr(c0, r1, 32'(q.chan))]
			    + fc * fr * src_pixels[pix_addr(c1, r1, 32'(q.chan))];
			e.range_error = 1'b0;
			e.pixel_out   = 16'((acc + 64'd8388608) >> 24);
		end
		exp_pixels_q.push_back(e);
	endfunction

	function automatic void check_pixel(input bir_pkg::rsp_t got);
		bir_pkg::rsp_t want;
		if (exp_pixels_q.size() == 0) begin
			$error("unexpected result: pixel_out=%h range_error=%b",
				got.pixel_out, got.range_error);
			err_cnt++;
			return;
		end
		want = exp_pixels_q.pop_front();
		if (got.pixel_out !== want.pixel_out) begin
			$error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
			err_cnt++;
		end
		if (got.range_error !== want.range_error) begin
			$error("range_error: expected %b, got %b", want.range_error, got.range_error);
			err_cnt++;
		end
	endfunction

	function automatic void gen_load(input int unsigned c, input int unsigned r,
		input int unsigned ch, input logic [bir_pkg::PIX_W-1:0] pix);
		bir_pkg::req_t q;
		q.req_type = bir_pkg::REQ_LOAD;
		q.col      = bir_pkg::COORD_W'(c);
		q.row      = bir_pkg::COORD_W'(r);
		q.chan     = 2'(ch);
		q.pixel_in = pix;
		req_pending_q.push_back(q);
		if (c < eff_iw && r < eff_ih) begin
			src_loaded[pix_addr(c, r, ch)] = 1'b1;
			gen_cnt++;
		end
	endfunction

	function automatic void fill_neighbour(input int unsigned c, input int unsigned r,
		input int unsigned ch);
		if (!src_loaded[pix_addr(c, r, ch)]) begin
			gen_load(c, r, ch, 8'($urandom));
		end
	endfunction

	// an in-range request only goes out once all four neighbours hold written pixels
	function automatic void gen_pixel_req(input int unsigned c, input int unsigned r,
		input int unsigned ch);
		int unsigned c0, c1, r0, r1;
		longint unsigned fc, fr;
		bir_pkg::req_t q;
		if (c < eff_ow && r < eff_oh) begin
			map_axis(c, col_step, eff_iw, c0, c1, fc);
			map_axis(r, row_step, eff_ih, r0, r1, fr);
			fill_neighbour(c0, r0, ch);
			fill_neighbour(c1, r0, ch);
			fill_neighbour(c0, r1, ch);
			fill_neighbour(c1, r1, ch);
		end
		q.req_type = bir_pkg::REQ_PIXEL;
		q.col      = bir_pkg::COORD_W'(c);
		q.row      = bir_pkg::COORD_W'(r);
		q.chan     = 2'(ch);
		q.pixel_in = 8'($urandom);
		req_pending_q.push_back(q);
		gen_cnt++;
	endfunction

	function automatic int unsigned pick_coord(input int unsigned sz);
		int unsigned hi;
		hi = (sz > 1024) ? 1023 : sz - 1;
		if ($urandom_range(0, 4) == 0) begin
			return $urandom_range(0, 1) ? hi : 0;
		end
		return $urandom_range(0, hi);
	endfunction

	function automatic void gen_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			gen_load($urandom_range(0, eff_iw - 1), $urandom_range(0, eff_ih - 1),
				$urandom_range(0, 3), 8'($urandom));
		end else if (pick < 30) begin
			gen_load($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 3),
				8'($urandom));
		end else if (pick < 90) begin
			gen_pixel_req(pick_coord(eff_ow), pick_coord(eff_oh), $urandom_range(0, 3));
		end else begin
			gen_pixel_req($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 3));
		end
	endfunction

	function automatic void directed_items();
		gen_load(0, 0, 0, 8'hFF);
		gen_load(1, 0, 0, 8'hFF);
		gen_load(0, 1, 0, 8'hFF);
		gen_load(1, 1, 0, 8'hFF);
		gen_pixel_req(0, 0, 0);
		gen_load(127, 127, 3, 8'h00);
		gen_pixel_req(127, 127, 3);
		gen_load(128, 0, 1, 8'hA5);
		gen_load(0, 128, 2, 8'h5A);
		gen_load(1023, 1023, 3, 8'hFF);
		gen_pixel_req(128, 0, 0);
		gen_pixel_req(0, 128, 1);
		gen_pixel_req(1023, 1023, 2);
		gen_pixel_req(1023, 0, 3);
		gen_load(64, 100, 2, 8'h00);
		gen_pixel_req(64, 100, 2);
		gen_pixel_req(127, 0, 1);
		gen_pixel_req(0, 127, 2);
	endfunction

	function automatic int pick_gap();
		int pick;
		if (send_run != 0) begin
			send_run--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			send_run = $urandom_range(20, 60);
			return 0;
		end
		if (pick < 60) begin
			return 0;
		end
		if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
		end else begin
			fire = req_valid && req_ready;
			if (fire) begin
				predict_resize(req_data);
				gap_left = pick_gap();
			end
			if (fire || !req_valid) begin
				if (gap_left == 0 && req_pending_q.size() != 0) begin
					req_data  <= req_pending_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
					if (gap_left != 0) begin
						gap_left--;
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_pulse) begin
			rsp_ready <= 1'b0;
			stall_cnt <= 150;
			run_cnt   <= 0;
		end else if (stall_cnt != 0) begin
			rsp_ready <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if (run_cnt != 0) begin
			rsp_ready <= 1'b1;
			run_cnt   <= run_cnt - 1;
		end else begin
			rdy_pick = $urandom_range(0, 99);
			if (rdy_pick < 60) begin
				rsp_ready <= 1'b1;
			end else if (rdy_pick < 90) begin
				rsp_ready <= 1'b0;
				stall_cnt <= $urandom_range(0, 3);
			end else if (rdy_pick < 96) begin
				rsp_ready <= 1'b0;
				stall_cnt <= $urandom_range(10, 40);
			end else begin
				rsp_ready <= 1'b1;
				run_cnt   <= $urandom_range(30, 80);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			check_pixel(rsp_data);
		end
	end

	task automatic apb_write(input bir_pkg::cfg_reg_t idx, input logic [31:0] wdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			bir_pkg::REG_IN_WIDTH: begin
				reg_in_w = wdata[bir_pkg::INSZ_W-1:0];
			end
			bir_pkg::REG_IN_HEIGHT: begin
				reg_in_h = wdata[bir_pkg::INSZ_W-1:0];
			end
			bir_pkg::REG_OUT_WIDTH: begin
				reg_out_w = wdata[bir_pkg::OUTSZ_W-1:0];
			end
			bir_pkg::REG_OUT_HEIGHT: begin
				reg_out_h = wdata[bir_pkg::OUTSZ_W-1:0];
			end
		endcase
		update_steps();
	endtask

	// loads have no result, so let the pipeline empty before touching config
	task automatic wait_idle();
		int n;
		n = 0;
		@(negedge clk);
		while ((req_pending_q.size() != 0 || req_valid || exp_pixels_q.size() != 0)
			&& n < 100000) begin
			@(negedge clk);
			n++;
		end
		if (req_pending_q.size() != 0 || req_valid || exp_pixels_q.size() != 0) begin
			$error("stalled: %0d requests unsent, %0d results outstanding",
				req_pending_q.size(), exp_pixels_q.size());
			err_cnt++;
		end
		repeat (12) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned iw, input int unsigned ih,
		input int unsigned ow, input int unsigned oh, input bit do_write, input bit squeeze);
		if (do_write) begin
			apb_write(bir_pkg::REG_IN_WIDTH, iw);
			apb_write(bir_pkg::REG_IN_HEIGHT, ih);
			apb_write(bir_pkg::REG_OUT_WIDTH, ow);
			apb_write(bir_pkg::REG_OUT_HEIGHT, oh);
		end
		@(negedge clk);
		gen_cnt = 0;
		while (gen_cnt < ITEMS_PER_PHASE) begin
			gen_random();
		end
		if (squeeze) begin
			@(posedge clk);
			hold_pulse <= 1'b1;
			@(posedge clk);
			hold_pulse <= 1'b0;
		end
		wait_idle();
	endtask

	initial begin
		reg_in_w  = 128;
		reg_in_h  = 128;
		reg_out_w = 128;
		reg_out_h = 128;
		update_steps();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed_items();
		run_phase(0, 0, 0, 0, 1'b0, 1'b0);
		run_phase(4, 3, 7, 5, 1'b1, 1'b1);
		run_phase(1, 1, 1, 1, 1'b1, 1'b0);
		run_phase(0, 0, 0, 0, 1'b1, 1'b0);
		run_phase(128, 128, 1024, 1024, 1'b1, 1'b0);
		run_phase(255, 200, 2047, 3, 1'b1, 1'b0);
		run_phase(16, 9, 5, 3, 1'b1, 1'b0);
		run_phase(2, 128, 1, 700, 1'b1, 1'b0);
		repeat (3) begin
			run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 40),
				$urandom_range(1, 40), 1'b1, 1'b0);
		end
		run_phase($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 2047),
			$urandom_range(0, 2047), 1'b1, 1'b0);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
